[hdl/lpht_pkg.sv]
// Package for the linear probe hash table: operation, result, slot mark and
// controller state encodings, plus the hash constants.
// No dependencies.
package lpht_pkg;

  // Request operations (code 3 is unused and answers not found)
  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_SEARCH = 2'd1,
    KIND_DELETE = 2'd2
  } kind_t;

  // Result codes
  typedef enum logic [1:0] {
    RC_OK        = 2'd0,
    RC_NOT_FOUND = 2'd1,
    RC_FULL      = 2'd2
  } rc_t;

  // Slot marks kept in the table memory
  typedef enum logic [1:0] {
    MARK_EMPTY   = 2'd0,
    MARK_FILLED  = 2'd1,
    MARK_DELETED = 2'd2
  } mark_t;

  // Controller states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HASH,
    ST_MOD,
    ST_ISSUE,
    ST_CHECK,
    ST_RESP
  } st_t;

  localparam logic [7:0] PAD_BYTE = 8'h2D;

  // djb2 start value
  localparam int HASH_SEED = 5381;

endpackage

[hdl/lpht_req_if.sv]
// Request channel of the linear probe hash table: valid/ready plus payload.
// No dependencies.
interface lpht_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [63:0] key;
  logic [3:0]  key_len;
  logic [63:0] value;
  logic [3:0]  value_len;

  modport source (output valid, kind, key, key_len, value, value_len, input ready);
  modport sink   (input valid, kind, key, key_len, value, value_len, output ready);
endinterface

[hdl/lpht_rsp_if.sv]
// Response channel of the linear probe hash table: valid/ready plus payload.
// No dependencies.
interface lpht_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  result_code;
  logic [63:0] found_value;

  modport source (output valid, result_code, found_value, input ready);
  modport sink   (input valid, result_code, found_value, output ready);
endinterface

[hdl/linear_probe_hash_table.sv]
// Linear probe hash table with djb2 home slot; table held in one memory.
// Depends on lpht_pkg, lpht_req_if, lpht_rsp_if.
//
//   channel | dir | word carries
//   --------+-----+------------------------------------------------
//   req     | in  | kind, key, key_len, value, value_len
//   rsp     | out | result_code, found_value
//
// One request at a time. After a request is taken, ST_HASH and ST_MOD fold
// the djb2 step for each key byte into a running remainder mod ENTRIES,
// ST_HASH then closes the hash, ST_ISSUE issues the first read, ST_CHECK
// handles the probes (at most ENTRIES of them) and ST_RESP loads the output
// register, after which the table returns to idle for the next request.
// After reset a clearing pass writes every slot empty, with req.ready low.
// A finished word waits in the output register while the next request is
// taken; a full output register holds the controller.
module linear_probe_hash_table
  import lpht_pkg::*;
#(
  parameter int ENTRIES     = 256,
  parameter int KEY_BYTES   = 8,
  parameter int VALUE_BYTES = 8
) (
  input logic       clk,
  input logic       rst,
  lpht_req_if.sink  req,
  lpht_rsp_if.source rsp
);

  localparam int IDX_W   = $clog2(ENTRIES);
  localparam int KEY_W   = 8 * KEY_BYTES;
  localparam int VALUE_W = 8 * VALUE_BYTES;
  localparam int WORD_W  = 2 + KEY_W + VALUE_W;
  localparam int ACC_W   = IDX_W + 8;
  localparam logic [ACC_W-1:0] ENT_A  = ACC_W'(ENTRIES);
  localparam logic [IDX_W-1:0] LAST_C = IDX_W'(ENTRIES - 1);
  localparam logic [IDX_W-1:0] SEED_C = IDX_W'(HASH_SEED % ENTRIES);
  localparam logic [3:0]       KB_C   = 4'(KEY_BYTES);
  localparam logic [3:0]       VB_C   = 4'(VALUE_BYTES);

  // Pad bytes at and above len with the pad character
  function automatic logic [63:0] pad_word(input logic [63:0] w, input logic [3:0] len);
    logic [63:0] r;
    r = '0;
    for (int i = 0; i < 8; i++) begin
      r[8*i +: 8] = (4'(i) < len) ? w[8*i +: 8] : PAD_BYTE;
    end
    return r;
  endfunction

  // Four restoring steps: take off ENTRIES << (base + k) where it fits, k = 3..0
  function automatic logic [ACC_W-1:0] reduce4(input logic [ACC_W-1:0] x,
                                               input int base);
    logic [ACC_W-1:0] t;
    logic [ACC_W-1:0] d;
    t = x;
    for (int k = 3; k >= 0; k--) begin
      d = ENT_A << (base + k);
      if (t >= d) t = t - d;
    end
    return t;
  endfunction

  // Registers
  st_t               st, st_next;
  logic [IDX_W-1:0]  clr_addr, clr_addr_next;
  logic [1:0]        op_kind, op_kind_next;
  logic [KEY_W-1:0]  pk, pk_next;
  logic [VALUE_W-1:0] pv, pv_next;
  logic [63:0]       key_sh, key_sh_next;
  logic [3:0]        klen, klen_next;
  logic [3:0]        bcnt, bcnt_next;
  logic [ACC_W-1:0]  acc, acc_next;
  logic [IDX_W-1:0]  idx, idx_next;
  logic [IDX_W-1:0]  pcnt, pcnt_next;
  logic [1:0]        res_code, res_code_next;
  logic [63:0]       res_value, res_value_next;
  logic              out_valid, out_valid_next;
  logic [1:0]        out_code;
  logic [63:0]       out_value;

  // Table memory: mark, padded key, padded value
  logic [WORD_W-1:0] mem [ENTRIES];
  logic [WORD_W-1:0] rd_word;
  logic [IDX_W-1:0]  rd_addr;
  logic              mem_we;
  logic [IDX_W-1:0]  mem_wa;
  logic [WORD_W-1:0] mem_wd;

  logic [1:0]        rd_mark;
  logic [KEY_W-1:0]  rd_key;
  logic [VALUE_W-1:0] rd_val;
  logic [IDX_W-1:0]  idx_inc;
  logic              hit, vacant, decided, out_load;
  logic [3:0]        req_klen, req_vlen;

  assign rd_mark = rd_word[WORD_W-1 -: 2];
  assign rd_key  = rd_word[KEY_W+VALUE_W-1 -: KEY_W];
  assign rd_val  = rd_word[VALUE_W-1:0];
  assign idx_inc = (idx == LAST_C) ? '0 : idx + 1'b1;
  assign hit     = (rd_mark == MARK_FILLED) && (rd_key == pk);
  assign vacant  = rd_mark inside {MARK_EMPTY, MARK_DELETED};
  assign req_klen = (req.key_len > KB_C) ? KB_C : req.key_len;
  assign req_vlen = (req.value_len > VB_C) ? VB_C : req.value_len;
  assign out_load = (st == ST_RESP) && (!out_valid || rsp.ready);

  assign req.ready       = (st == ST_IDLE);
  assign rsp.valid       = out_valid;
  assign rsp.result_code = out_code;
  assign rsp.found_value = out_value;

  // Memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    rd_word <= mem[rd_addr];
  end

  // Next state and datapath control
  always_comb begin
    st_next        = st;
    clr_addr_next  = clr_addr;
    op_kind_next   = op_kind;
    pk_next        = pk;
    pv_next        = pv;
    key_sh_next    = key_sh;
    klen_next      = klen;
    bcnt_next      = bcnt;
    acc_next       = acc;
    idx_next       = idx;
    pcnt_next      = pcnt;
    res_code_next  = res_code;
    res_value_next = res_value;
    rd_addr        = idx;
    mem_we         = 1'b0;
    mem_wa         = idx;
    mem_wd         = {MARK_FILLED, pk, pv};
    decided        = 1'b0;
    case (st)
      ST_CLEAR: begin
        mem_we        = 1'b1;
        mem_wa        = clr_addr;
        mem_wd        = {MARK_EMPTY, {(KEY_W+VALUE_W){1'b0}}};
        clr_addr_next = clr_addr + 1'b1;
        if (clr_addr == LAST_C) st_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (req.valid) begin
          op_kind_next   = req.kind;
          pk_next        = KEY_W'(pad_word(req.key, req_klen));
          pv_next        = VALUE_W'(pad_word(req.value, req_vlen));
          key_sh_next    = req.key;
          klen_next      = req_klen;
          bcnt_next      = '0;
          idx_next       = SEED_C;
          res_value_next = '0;
          if (req.kind inside {KIND_INSERT, KIND_SEARCH, KIND_DELETE}) begin
            st_next = ST_HASH;
          end else begin
            res_code_next = RC_NOT_FOUND;
            st_next       = ST_RESP;
          end
        end
      end
      ST_HASH: begin
        // rem*33 + byte, upper half of the reduction mod ENTRIES
        if (bcnt == klen) begin
          pcnt_next = '0;
          st_next   = ST_ISSUE;
        end else begin
          acc_next = reduce4(ACC_W'({idx, 5'b0}) + ACC_W'(idx) + ACC_W'(key_sh[7:0]), 4);
          st_next  = ST_MOD;
        end
      end
      ST_MOD: begin
        // lower half of the reduction; remainder is the running home slot
        idx_next    = IDX_W'(reduce4(acc, 0));
        key_sh_next = key_sh >> 8;
        bcnt_next   = bcnt + 1'b1;
        st_next     = ST_HASH;
      end
      ST_ISSUE: begin
        st_next = ST_CHECK;
      end
      ST_CHECK: begin
        // read data of slot idx is here; next slot is read meanwhile
        rd_addr = idx_inc;
        if (op_kind == KIND_INSERT) begin
          if (vacant || hit) begin
            mem_we        = 1'b1;
            mem_wd        = {MARK_FILLED, pk, pv};
            res_code_next = RC_OK;
            decided       = 1'b1;
          end
        end else begin
          if (rd_mark == MARK_EMPTY) begin
            res_code_next = RC_NOT_FOUND;
            decided       = 1'b1;
          end else if (hit) begin
            res_code_next = RC_OK;
            decided       = 1'b1;
            if (op_kind == KIND_SEARCH) begin
              res_value_next = 64'(rd_val);
            end else begin
              mem_we = 1'b1;
              mem_wd = {MARK_DELETED, rd_key, rd_val};
            end
          end
        end
        if (decided) begin
          st_next = ST_RESP;
        end else if (pcnt == LAST_C) begin
          // full circuit without a result
          res_code_next = (op_kind == KIND_INSERT) ? RC_FULL : RC_NOT_FOUND;
          st_next       = ST_RESP;
        end else begin
          idx_next  = idx_inc;
          pcnt_next = pcnt + 1'b1;
        end
      end
      ST_RESP: begin
        if (out_load) st_next = ST_IDLE;
      end
      default: st_next = ST_IDLE;
    endcase
  end

  // Output register valid
  always_comb begin
    if (out_load) out_valid_next = 1'b1;
    else if (rsp.ready) out_valid_next = 1'b0;
    else out_valid_next = out_valid;
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= ST_CLEAR;
      clr_addr  <= '0;
      out_valid <= 1'b0;
    end else begin
      st        <= st_next;
      clr_addr  <= clr_addr_next;
      out_valid <= out_valid_next;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    op_kind   <= op_kind_next;
    pk        <= pk_next;
    pv        <= pv_next;
    key_sh    <= key_sh_next;
    klen      <= klen_next;
    bcnt      <= bcnt_next;
    acc       <= acc_next;
    idx       <= idx_next;
    pcnt      <= pcnt_next;
    res_code  <= res_code_next;
    res_value <= res_value_next;
    if (out_load) begin
      out_code  <= res_code;
      out_value <= res_value;
    end
  end

endmodule

[hdl/lpht_chk.sv]
// Port-level checks for the linear probe hash table, bound to the top level.
// Depends on lpht_pkg and linear_probe_hash_table.
module lpht_chk
  import lpht_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        req_valid,
  input logic        req_ready,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic [1:0]  result_code,
  input logic [63:0] found_value
);

  logic [1:0] pending;

  // Requests taken minus words delivered
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + 2'(req_valid && req_ready) - 2'(rsp_valid && rsp_ready);
    end
  end

  // Clearing pass keeps requests out right after reset
  a_clear_after_reset: assert property (@(posedge clk) rst |=> !req_ready)
    else $error("request taken during clearing pass");

  // Every delivered word answers a request
  a_no_extra_word: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_ready) |-> (pending != 2'd0))
    else $error("response word without a request");

  // Value is only reported on a successful lookup
  a_value_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && (result_code != RC_OK)) |-> (found_value == 64'd0))
    else $error("found_value nonzero on a failed request");

  // Stalled response word holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |=>
      (rsp_valid && $stable(result_code) && $stable(found_value)))
    else $error("response word changed while stalled");

endmodule

bind linear_probe_hash_table lpht_chk u_lpht_chk (
  .clk         (clk),
  .rst         (rst),
  .req_valid   (req.valid),
  .req_ready   (req.ready),
  .rsp_valid   (rsp.valid),
  .rsp_ready   (rsp.ready),
  .result_code (rsp.result_code),
  .found_value (rsp.found_value)
);
